FILE: rtl/core/sisk_pkg.sv
// Shared types and constants for the stable insertion sort block.
package sisk_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_TAG_BITS    = 16;
    localparam int KEY_W           = 32;
    localparam int IO_TAG_W        = 16;
    localparam int TRACK_W         = 4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FIX,
        ST_EMIT
    } state_t;

    // Chain command: insert the incoming record, or shift every cell one place toward the head.
    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctl_t;

endpackage

FILE: rtl/core/stable_insertion_sort_by_key.sv
// Top level of the stable insertion sorter with a tracked entry.
//
// Records (signed key plus tag) are taken one per cycle while busy is low, at
// each edge with start high. Every record drops straight into its place in a
// chain of MAX_ENTRIES cells: cells whose key is strictly greater than the new
// key shift down one place, so equal keys keep their arrival order. Records
// beyond MAX_ENTRIES are dropped. The record that arrives at the position held
// by the tracked slot register carries a tracked mark through the chain. When
// the record marked last has been taken, busy rises: a fold state first turns
// the tracked mark back into a slot index, then the chain shifts out one record
// per cycle, and each result beat appears in the cycle after the chain shift
// that produced it. Results are shown for exactly one cycle under valid and
// cannot be held off; the final beat of a run carries out_last. A new list may
// start while the final beat is still on the result ports. If the tracked
// record was not part of a list, the tracked slot keeps its old value and no
// beat carries is_tracked.
module stable_insertion_sort_by_key #(
    parameter int MAX_ENTRIES = sisk_pkg::DEF_MAX_ENTRIES,
    parameter int TAG_BITS    = sisk_pkg::DEF_TAG_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sisk_pkg::KEY_W-1:0]   sort_key,
    input  logic        [sisk_pkg::IO_TAG_W-1:0] entry_tag,
    input  logic                                last,
    output logic                                valid,
    output logic signed [sisk_pkg::KEY_W-1:0]   out_key,
    output logic        [sisk_pkg::IO_TAG_W-1:0] out_tag,
    output logic                                is_tracked,
    output logic        [sisk_pkg::TRACK_W-1:0] tracked_index,
    output logic                                out_last
);
    import sisk_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    chain_ctl_t          ctl;
    logic                new_flag;
    logic                last_beat;
    logic [IDX_W-1:0]    tslot;
    logic                any_flag;
    logic [IDX_W-1:0]    flag_idx;
    logic [TAG_BITS-1:0] new_tag;

    // per-cell taps of the chain
    logic                    c_valid [MAX_ENTRIES];
    logic signed [KEY_W-1:0] c_key   [MAX_ENTRIES];
    logic [TAG_BITS-1:0]     c_tag   [MAX_ENTRIES];
    logic                    c_flag  [MAX_ENTRIES];
    logic                    c_gt    [MAX_ENTRIES];

    // result beat registers
    logic                    valid_reg;
    logic                    last_reg;
    logic                    tracked_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [IO_TAG_W-1:0]     tag_reg;
    logic [TRACK_W-1:0]      tidx_reg;

    assign new_tag = TAG_BITS'(entry_tag);

    sisk_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last      (last),
        .any_flag  (any_flag),
        .flag_idx  (flag_idx),
        .busy      (busy),
        .ctl       (ctl),
        .new_flag  (new_flag),
        .last_beat (last_beat),
        .tslot     (tslot)
    );

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic                    p_valid, p_gt, p_flag;
        logic signed [KEY_W-1:0] p_key;
        logic [TAG_BITS-1:0]     p_tag;
        logic                    n_valid, n_flag;
        logic signed [KEY_W-1:0] n_key;
        logic [TAG_BITS-1:0]     n_tag;

        if (i == 0)
        begin : g_head
            // head of chain: a virtual neighbour that always stays put
            assign p_valid = 1'b1;
            assign p_gt    = 1'b0;
            assign p_flag  = 1'b0;
            assign p_key   = sort_key;
            assign p_tag   = new_tag;
        end
        else
        begin : g_mid
            assign p_valid = c_valid[i-1];
            assign p_gt    = c_gt[i-1];
            assign p_flag  = c_flag[i-1];
            assign p_key   = c_key[i-1];
            assign p_tag   = c_tag[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_flag  = 1'b0;
            assign n_key   = '0;
            assign n_tag   = '0;
        end
        else
        begin : g_body
            assign n_valid = c_valid[i+1];
            assign n_flag  = c_flag[i+1];
            assign n_key   = c_key[i+1];
            assign n_tag   = c_tag[i+1];
        end

        sisk_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .new_key    (sort_key),
            .new_tag    (new_tag),
            .new_flag   (new_flag),
            .prev_valid (p_valid),
            .prev_gt    (p_gt),
            .prev_key   (p_key),
            .prev_tag   (p_tag),
            .prev_flag  (p_flag),
            .nxt_valid  (n_valid),
            .nxt_key    (n_key),
            .nxt_tag    (n_tag),
            .nxt_flag   (n_flag),
            .valid      (c_valid[i]),
            .key        (c_key[i]),
            .tag        (c_tag[i]),
            .flag       (c_flag[i]),
            .gt         (c_gt[i])
        );
    end

    // At most one cell holds the tracked mark: fold it to an index.
    always_comb
    begin
        any_flag = 1'b0;
        flag_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            any_flag = any_flag | c_flag[i];
            flag_idx = flag_idx | (c_flag[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

    // Result beat: captured from the chain head on each shift.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= ctl.shift;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            key_reg     <= c_key[0];
            tag_reg     <= IO_TAG_W'(c_tag[0]);
            tracked_reg <= c_flag[0];
            tidx_reg    <= TRACK_W'(tslot);
            last_reg    <= last_beat;
        end
    end

    assign valid         = valid_reg;
    assign out_key       = key_reg;
    assign out_tag       = tag_reg;
    assign is_tracked    = tracked_reg;
    assign tracked_index = tidx_reg;
    assign out_last      = last_reg;

endmodule

FILE: rtl/core/sisk_cell.sv
// One cell of the sorted chain: holds a record and compares it against the incoming key.
module sisk_cell #(
    parameter int TAG_BITS = sisk_pkg::DEF_TAG_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sisk_pkg::chain_ctl_t                ctl,
    input  logic signed [sisk_pkg::KEY_W-1:0]   new_key,
    input  logic        [TAG_BITS-1:0]          new_tag,
    input  logic                                new_flag,
    input  logic                                prev_valid,
    input  logic                                prev_gt,
    input  logic signed [sisk_pkg::KEY_W-1:0]   prev_key,
    input  logic        [TAG_BITS-1:0]          prev_tag,
    input  logic                                prev_flag,
    input  logic                                nxt_valid,
    input  logic signed [sisk_pkg::KEY_W-1:0]   nxt_key,
    input  logic        [TAG_BITS-1:0]          nxt_tag,
    input  logic                                nxt_flag,
    output logic                                valid,
    output logic signed [sisk_pkg::KEY_W-1:0]   key,
    output logic        [TAG_BITS-1:0]          tag,
    output logic                                flag,
    output logic                                gt
);
    import sisk_pkg::*;

    logic                    valid_reg, valid_next;
    logic                    flag_reg, flag_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0]     tag_reg, tag_next;
    logic                    move;

    // strictly greater: equal keys stay ahead of the newcomer
    assign gt   = valid_reg && (key_reg > new_key);
    assign move = valid_reg ? gt : prev_valid;

    always_comb
    begin
        valid_next = valid_reg;
        flag_next  = flag_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctl.shift)
        begin
            valid_next = nxt_valid;
            flag_next  = nxt_flag;
            key_next   = nxt_key;
            tag_next   = nxt_tag;
        end
        else if (ctl.insert && move)
        begin
            valid_next = 1'b1;
            if (prev_gt)
            begin
                flag_next = prev_flag;
                key_next  = prev_key;
                tag_next  = prev_tag;
            end
            else
            begin
                flag_next = new_flag;
                key_next  = new_key;
                tag_next  = new_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign valid = valid_reg;
    assign flag  = flag_reg;
    assign key   = key_reg;
    assign tag   = tag_reg;

endmodule

FILE: rtl/core/sisk_ctrl.sv
// Sequencer: load count, tracked slot register and the load/resolve/emit state machine.
module sisk_ctrl #(
    parameter int MAX_ENTRIES = sisk_pkg::DEF_MAX_ENTRIES,
    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 last,
    input  logic                 any_flag,
    input  logic [IDX_W-1:0]     flag_idx,
    output logic                 busy,
    output sisk_pkg::chain_ctl_t ctl,
    output logic                 new_flag,
    output logic                 last_beat,
    output logic [IDX_W-1:0]     tslot
);
    import sisk_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] beat_reg, beat_next;
    logic [IDX_W-1:0] tslot_reg, tslot_next;
    logic             accept;
    logic             full;

    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign accept   = start && (state_reg == ST_LOAD);
    assign new_flag = (count_reg[IDX_W-1:0] == tslot_reg);
    assign last_beat = ((beat_reg + CNT_W'(1)) == count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept && last)
                    state_next = ST_FIX;
            end
            ST_FIX:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (last_beat)
                    state_next = ST_LOAD;
            end
            default:
                state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb
    begin
        busy       = 1'b1;
        ctl.insert = 1'b0;
        ctl.shift  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                busy       = 1'b0;
                ctl.insert = accept && !full;
            end
            ST_FIX:
                busy = 1'b1;
            ST_EMIT:
                ctl.shift = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        beat_next  = beat_reg;
        tslot_next = tslot_reg;
        if (ctl.insert)
            count_next = count_reg + CNT_W'(1);
        if (state_reg == ST_FIX)
        begin
            beat_next = '0;
            if (any_flag)
                tslot_next = flag_idx;
        end
        if (ctl.shift)
        begin
            beat_next = beat_reg + CNT_W'(1);
            if (last_beat)
                count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            beat_reg  <= '0;
            tslot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            beat_reg  <= beat_next;
            tslot_reg <= tslot_next;
        end
    end

    assign tslot = tslot_reg;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the stable insertion sorter with its tracked entry.
module tb_top;

    import sisk_pkg::*;

    localparam int DEPTH        = DEF_MAX_ENTRIES;
    localparam int RANDOM_ITEMS = 300;
    localparam int MAX_REPORTS  = 10;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [KEY_W-1:0]   sort_key;
    logic [IO_TAG_W-1:0]       entry_tag;
    logic                      last;
    logic                      valid;
    logic signed [KEY_W-1:0]   out_key;
    logic [IO_TAG_W-1:0]       out_tag;
    logic                      is_tracked;
    logic [TRACK_W-1:0]        tracked_index;
    logic                      out_last;

    // One sorted output beat as the block should present it.
    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [IO_TAG_W-1:0]     tag;
        logic                    trk;
        logic [TRACK_W-1:0]      tidx;
        logic                    lst;
    } sorted_beat_t;

    // Beats still owed by the block, oldest first.
    sorted_beat_t            sorted_beats_due[$];
    sorted_beat_t            due_beat;

    // Shadow of the record store: the list being loaded, plus the tracked slot.
    logic signed [KEY_W-1:0] held_key [DEPTH];
    logic [IO_TAG_W-1:0]     held_tag [DEPTH];
    int                      held_cnt;
    int                      track_pos;

    int                      fault_cnt;
    int                      beats_seen;
    int                      lists_sent;
    int                      recs_sent;
    int                      recs_dropped;
    int                      burst_left;

    stable_insertion_sort_by_key #(
        .MAX_ENTRIES (DEF_MAX_ENTRIES),
        .TAG_BITS    (DEF_TAG_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .sort_key      (sort_key),
        .entry_tag     (entry_tag),
        .last          (last),
        .valid         (valid),
        .out_key       (out_key),
        .out_tag       (out_tag),
        .is_tracked    (is_tracked),
        .tracked_index (tracked_index),
        .out_last      (out_last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Counts every failure; only the first MAX_REPORTS are printed in full.
    task automatic note_fault(input string what);
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
        begin
            $display("%s", what);
        end
    endtask

    // Shadow of the block's behaviour for one accepted record. Records past the
    // store depth are lost; a record marked last closes the list, which is then
    // insertion-sorted (strictly-less moves only, so ties keep arrival order)
    // with the tracked slot following its record through every exchange.
    task automatic take_record(input logic signed [KEY_W-1:0] key,
                               input logic [IO_TAG_W-1:0] tag,
                               input logic lst);
        int                      i;
        int                      j;
        logic signed [KEY_W-1:0] swap_key;
        logic [IO_TAG_W-1:0]     swap_tag;
        sorted_beat_t            b;
        if (held_cnt < DEPTH)
        begin
            held_key[held_cnt] = key;
            held_tag[held_cnt] = tag;
            held_cnt++;
        end
        else
        begin
            recs_dropped++;
        end
        if (lst)
        begin
            for (i = 1; i < held_cnt; i++)
            begin
                j = i;
                while (j > 0 && held_key[j] < held_key[j-1])
                begin
                    swap_key      = held_key[j];
                    swap_tag      = held_tag[j];
                    held_key[j]   = held_key[j-1];
                    held_tag[j]   = held_tag[j-1];
                    held_key[j-1] = swap_key;
                    held_tag[j-1] = swap_tag;
                    if (track_pos == j)
                    begin
                        track_pos = j - 1;
                    end
                    else if (track_pos == j - 1)
                    begin
                        track_pos = j;
                    end
                    j--;
                end
            end
            // tracked slot beyond the list: nothing moves it, no beat is marked
            for (i = 0; i < held_cnt; i++)
            begin
                b.key  = held_key[i];
                b.tag  = held_tag[i];
                b.trk  = (i == track_pos);
                b.tidx = track_pos[TRACK_W-1:0];
                b.lst  = (i == held_cnt - 1);
                sorted_beats_due.push_back(b);
            end
            held_cnt = 0;
            lists_sent++;
        end
    endtask

    // Sender pacing: bursts of random length, then a random gap. Some gaps run
    // long enough to straddle the fold and emit cycles of a finished list.
    task automatic pause_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 4))
            0:       gap = 0;
            1:       gap = $urandom_range(9, 24);
            default: gap = $urandom_range(1, 8);
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offers one record and holds it until the block takes the beat.
    task automatic push_record(input logic signed [KEY_W-1:0] key,
                               input logic [IO_TAG_W-1:0] tag,
                               input logic lst);
        pause_sender();
        start     <= 1'b1;
        sort_key  <= key;
        entry_tag <= tag;
        last      <= lst;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        take_record(key, tag, lst);
        recs_sent++;
    endtask

    // Keys: extremes, a narrow band that forces ties, or anything at all.
    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       k = {1'b1, {(KEY_W-1){1'b0}}};
                    1:       k = {1'b0, {(KEY_W-1){1'b1}}};
                    2:       k = '0;
                    default: k = '1;
                endcase
            end
            1, 2, 3, 4: k = $signed($urandom_range(0, 8)) - 4;
            default:    k = $urandom;
        endcase
        return k;
    endfunction

    // Single-record list: shortest run, last beat is also the first.
    task automatic test_single_record();
        push_record({1'b0, {(KEY_W-1){1'b1}}}, 16'hFFFF, 1'b1);
    endtask

    // Extreme keys with duplicates; tags tell tied records apart.
    task automatic test_extremes_and_ties();
        push_record('0,                           16'h0000, 1'b0);
        push_record({1'b0, {(KEY_W-1){1'b1}}},    16'h1111, 1'b0);
        push_record({1'b1, {(KEY_W-1){1'b0}}},    16'h2222, 1'b0);
        push_record('1,                           16'h3333, 1'b0);
        push_record('0,                           16'h4444, 1'b0);
        push_record({1'b1, {(KEY_W-1){1'b0}}},    16'hFFFF, 1'b1);
    endtask

    // Over-full list in falling key order: the excess, last one included, is
    // lost but still closes the list, and the tracked record travels far.
    task automatic test_store_full();
        int i;
        for (i = 0; i < DEPTH + 2; i++)
        begin
            push_record(KEY_W'(100 - 7 * i), IO_TAG_W'(16'hA000 + i), i == DEPTH + 1);
        end
    endtask

    // Random lists: mostly short, some exactly full, a few over-full.
    task automatic test_random_lists();
        int stored;
        int len;
        int i;
        stored = 0;
        while (stored < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2: len = DEPTH;
                3:       len = $urandom_range(DEPTH + 1, DEPTH + 4);
                default: len = $urandom_range(1, 8);
            endcase
            for (i = 0; i < len; i++)
            begin
                push_record(pick_key(), IO_TAG_W'($urandom), i == len - 1);
            end
            stored += (len > DEPTH) ? DEPTH : len;
        end
    endtask

    // Result side: every strobed beat must match the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            beats_seen++;
            if (sorted_beats_due.size() == 0)
            begin
                note_fault($sformatf("unexpected beat: key %0d tag %h trk %b idx %0d last %b",
                                     out_key, out_tag, is_tracked, tracked_index, out_last));
            end
            else
            begin
                due_beat = sorted_beats_due.pop_front();
                if (out_key !== due_beat.key || out_tag !== due_beat.tag
                    || is_tracked !== due_beat.trk || tracked_index !== due_beat.tidx
                    || out_last !== due_beat.lst)
                begin
                    note_fault($sformatf(
                        "beat mismatch: key %0d/%0d tag %h/%h trk %b/%b idx %0d/%0d last %b/%b",
                        out_key, due_beat.key, out_tag, due_beat.tag,
                        is_tracked, due_beat.trk, tracked_index, due_beat.tidx,
                        out_last, due_beat.lst));
                end
            end
        end
    end

    initial
    begin
        int spin;
        rst_n        = 1'b0;
        start        = 1'b0;
        sort_key     = '0;
        entry_tag    = '0;
        last         = 1'b0;
        held_cnt     = 0;
        track_pos    = 0;
        fault_cnt    = 0;
        beats_seen   = 0;
        lists_sent   = 0;
        recs_sent    = 0;
        recs_dropped = 0;
        burst_left   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_record();
        test_extremes_and_ties();
        test_store_full();
        test_random_lists();

        start <= 1'b0;
        // drain: allow the last list its fold step plus one beat per record
        spin = 0;
        while (sorted_beats_due.size() > 0 && spin < 20000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (DEPTH + 4) @(posedge clk);
        if (sorted_beats_due.size() != 0)
        begin
            note_fault($sformatf("%0d beats never arrived", sorted_beats_due.size()));
        end

        $display("tb_top: %0d records in %0d lists (%0d lost to a full store)",
                 recs_sent, lists_sent, recs_dropped);
        $display("tb_top: %0d sorted beats checked, %0d faults", beats_seen, fault_cnt);
        if (fault_cnt == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: stable_insertion_sort_by_key.f
rtl/core/sisk_pkg.sv
rtl/core/sisk_cell.sv
rtl/core/sisk_ctrl.sv
rtl/core/stable_insertion_sort_by_key.sv
tb/tb_top.sv
